// ===== rtl/core/srdp_pkg.sv =====
`default_nettype none
package srdp_pkg;

  localparam int RING_MAX    = 256;
  localparam int RING_LG_RAW = $clog2(RING_MAX + 1) - 1;
  localparam int RING_LG     = (RING_LG_RAW > 8) ? 8 : RING_LG_RAW;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [3:0]  RING_LG_RESET = 4'd8;
  localparam logic [15:0] DESC_F_NEXT   = 16'h0001;

  localparam int CFG_ADDR_W = 3;
  localparam logic        REG_RING_SIZE = 1'b0;

  typedef enum logic {
    IN_SUBMIT = 1'b0,
    IN_POLL   = 1'b1
  } in_kind_t;

  typedef enum logic [1:0] {
    REC_DESC    = 2'd0,
    REC_AVAIL   = 2'd1,
    REC_COMPL   = 2'd2,
    REC_NOTRDY  = 2'd3
  } rec_kind_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] seg_addr;
    logic [31:0] seg_len;
    logic [15:0] seg_flags;
    logic        seg_last;
    logic [15:0] device_used_idx;
    logic [31:0] used_entry_len;
  } in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  slot;
    logic [63:0] desc_addr;
    logic [31:0] desc_len;
    logic [15:0] desc_flags;
    logic [7:0]  desc_next;
    logic [7:0]  ring_head;
    logic [15:0] new_avail_idx;
    logic [31:0] used_len;
    logic        last;
  } out_t;

  typedef struct packed {
    out_t        rec0;
    logic        two;
    logic [7:0]  avail_slot;
    logic [7:0]  head;
    logic [15:0] new_avail;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/core/srdp_front.sv =====
`default_nettype none
module srdp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [3:0]     ring_lg,
  input  logic           in_push,
  input  srdp_pkg::in_t  in_data,
  input  logic           q_full,
  output logic           q_push,
  output srdp_pkg::op_t  q_op
);
  import srdp_pkg::*;

  logic [7:0]  free_head_r, free_head_nxt;
  logic [7:0]  chain_head_r, chain_head_nxt;
  logic [7:0]  chain_pos_r, chain_pos_nxt;
  logic [15:0] avail_index_r, avail_index_nxt;
  logic [15:0] consumed_r, consumed_nxt;

  logic [3:0]  lg_eff;
  logic [8:0]  mask9;
  logic [7:0]  mask;
  logic [7:0]  head;
  logic [7:0]  sum;
  logic [7:0]  idx;
  logic [7:0]  nxt;
  logic        accept;

  assign lg_eff = (ring_lg > 4'(RING_LG)) ? 4'(RING_LG) : ring_lg;
  assign mask9  = (9'd1 << lg_eff) - 9'd1;
  assign mask   = mask9[7:0];
  assign head   = (chain_pos_r == 8'd0) ? free_head_r : chain_head_r;
  assign sum    = head + chain_pos_r;
  assign idx    = sum & mask;
  assign nxt    = (sum + 8'd1) & mask;
  assign accept = in_push && !q_full;
  assign q_push = accept;

  always_comb begin
    free_head_nxt   = free_head_r;
    chain_head_nxt  = chain_head_r;
    chain_pos_nxt   = chain_pos_r;
    avail_index_nxt = avail_index_r;
    consumed_nxt    = consumed_r;
    q_op            = '0;
    if (in_data.kind == IN_POLL) begin
      q_op.rec0.last = 1'b1;
      if (in_data.device_used_idx == consumed_r) begin
        q_op.rec0.record_kind = REC_NOTRDY;
      end else begin
        q_op.rec0.record_kind = REC_COMPL;
        q_op.rec0.slot        = consumed_r[7:0] & mask;
        q_op.rec0.used_len    = in_data.used_entry_len;
        consumed_nxt          = consumed_r + 16'd1;
      end
    end else begin
      q_op.rec0.record_kind = REC_DESC;
      q_op.rec0.slot        = idx;
      q_op.rec0.desc_addr   = in_data.seg_addr;
      q_op.rec0.desc_len    = in_data.seg_len;
      chain_head_nxt        = head;
      if (!in_data.seg_last) begin
        q_op.rec0.desc_flags = in_data.seg_flags | DESC_F_NEXT;
        q_op.rec0.desc_next  = nxt;
        q_op.rec0.last       = 1'b1;
        chain_pos_nxt        = chain_pos_r + 8'd1;
      end else begin
        q_op.rec0.desc_flags = in_data.seg_flags;
        q_op.two             = 1'b1;
        q_op.avail_slot      = avail_index_r[7:0] & mask;
        q_op.head            = head;
        q_op.new_avail       = avail_index_r + 16'd1;
        avail_index_nxt      = avail_index_r + 16'd1;
        free_head_nxt        = nxt;
        chain_pos_nxt        = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r   <= '0;
      chain_head_r  <= '0;
      chain_pos_r   <= '0;
      avail_index_r <= '0;
      consumed_r    <= '0;
    end else if (accept) begin
      free_head_r   <= free_head_nxt;
      chain_head_r  <= chain_head_nxt;
      chain_pos_r   <= chain_pos_nxt;
      avail_index_r <= avail_index_nxt;
      consumed_r    <= consumed_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/srdp_fifo.sv =====
`default_nettype none
module srdp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srdp_pkg::op_t  push_op,
  input  logic           pop,
  output srdp_pkg::op_t  head_op,
  output logic           full,
  output logic           empty
);
  import srdp_pkg::*;

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == QCNT_W'(QDEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue count missed a push");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/srdp_back.sv =====
`default_nettype none
module srdp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  srdp_pkg::op_t  head_op,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output srdp_pkg::out_t out_data
);
  import srdp_pkg::*;

  out_t out_r, out_nxt;
  logic valid_r, valid_nxt;
  logic phase_r, phase_nxt;
  logic load;
  out_t avail_rec;

  assign out_empty = !valid_r;
  assign out_data  = out_r;
  assign load      = !valid_r || out_pop;

  always_comb begin
    avail_rec               = '0;
    avail_rec.record_kind   = REC_AVAIL;
    avail_rec.slot          = head_op.avail_slot;
    avail_rec.ring_head     = head_op.head;
    avail_rec.new_avail_idx = head_op.new_avail;
    avail_rec.last          = 1'b1;
  end

  always_comb begin
    out_nxt   = out_r;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        if (phase_r) begin
          out_nxt   = avail_rec;
          q_pop     = 1'b1;
          phase_nxt = 1'b0;
        end else begin
          out_nxt   = head_op.rec0;
          q_pop     = !head_op.two;
          phase_nxt = head_op.two;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_phase_q: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_empty)
    else $error("second request pending with empty queue");
  a_phase_desc: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (valid_r && out_r.record_kind == REC_DESC && !out_r.last))
    else $error("pending ring write without its descriptor");
  a_last_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_r.record_kind != REC_DESC) |-> out_r.last)
    else $error("non-descriptor request without last");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/split_ring_descriptor_producer_top.sv =====
// an accepted request is written into the queue, then registered in the output stage before it reaches the result ports
// throughput: one request accepted per cycle while the queue is not full; a closing segment yields two result records
// a four-entry queue between classifier and output stage absorbs result stalls
// reset: synchronous active-low rst_n clears ring indices, queue and output
// reset: ring_size_log2 returns to 8
`default_nettype none
module split_ring_descriptor_producer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  srdp_pkg::in_t                      in_data,
  output logic                               out_empty,
  input  logic                               out_pop,
  output srdp_pkg::out_t                     out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srdp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import srdp_pkg::*;

  logic [3:0] ring_lg_r;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  op_t        push_op;
  op_t        head_op;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RING_SIZE) ? {28'd0, ring_lg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_lg_r <= RING_LG_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RING_SIZE) begin
      ring_lg_r <= pwdata[3:0];
    end
  end

  assign in_full = q_full;

  srdp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ring_lg (ring_lg_r),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (push_op)
  );

  srdp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  srdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
  import srdp_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam logic [CFG_ADDR_W-1:0] RING_SIZE_ADDR = CFG_ADDR_W'(4 * REG_RING_SIZE);

  typedef enum bit {DO_REQUEST, DO_RING_SIZE} row_op_t;

  typedef struct {
    row_op_t    op;
    in_t        req;
    logic [3:0] lg;
    bit         typed;
    out_t       want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_t                   in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_t                  out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // ring state as the driver sees it
  logic [3:0]  ring_lg = RING_LG_RESET;
  logic [7:0]  next_free = '0;
  logic [7:0]  open_head = '0;
  logic [7:0]  open_len = '0;
  logic [15:0] published = '0;
  logic [15:0] reaped = '0;

  out_t      awaited_records[$];
  plan_row_t plan[$];
  int        fail_count = 0;
  int        quiet = 0;
  int        pop_hold = 0;
  bit        no_idle = 1'b0;

  split_ring_descriptor_producer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic void predict_records(input in_t req);
    int         lg_eff;
    logic [7:0] mask;
    logic [7:0] idx;
    logic [7:0] nxt;
    out_t       r0;
    out_t       r1;
    lg_eff = (ring_lg > 4'd8) ? 8 : int'(ring_lg);
    mask = 8'((1 << lg_eff) - 1);
    r0 = '0;
    r1 = '0;
    r0.last = 1'b1;
    if (req.kind == IN_POLL) begin
      if (req.device_used_idx == reaped) begin
        r0.record_kind = REC_NOTRDY;
      end else begin
        r0.record_kind = REC_COMPL;
        r0.slot = reaped[7:0] & mask;
        r0.used_len = req.used_entry_len;
        reaped = reaped + 16'd1;
      end
      awaited_records.push_back(r0);
      return;
    end
    if (open_len == 8'd0) open_head = next_free;
    idx = (open_head + open_len) & mask;
    nxt = (open_head + open_len + 8'd1) & mask;
    r0.record_kind = REC_DESC;
    r0.slot = idx;
    r0.desc_addr = req.seg_addr;
    r0.desc_len = req.seg_len;
    if (!req.seg_last) begin
      r0.desc_flags = req.seg_flags | DESC_F_NEXT;
      r0.desc_next = nxt;
      open_len = open_len + 8'd1;
      awaited_records.push_back(r0);
      return;
    end
    r0.desc_flags = req.seg_flags;
    r0.last = 1'b0;
    r1.record_kind = REC_AVAIL;
    r1.slot = published[7:0] & mask;
    r1.ring_head = open_head;
    r1.new_avail_idx = published + 16'd1;
    r1.last = 1'b1;
    published = published + 16'd1;
    next_free = nxt;
    open_len = '0;
    awaited_records.push_back(r0);
    awaited_records.push_back(r1);
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_t rand_request(input in_kind_t k, input logic closing);
    in_t req;
    req.kind = k;
    req.seg_addr = {$urandom, $urandom};
    req.seg_len = $urandom;
    req.seg_flags = 16'($urandom);
    req.seg_last = closing;
    req.device_used_idx = 16'($urandom);
    req.used_entry_len = $urandom;
    return req;
  endfunction

  function automatic in_t seg_req(input logic [63:0] a, input logic [31:0] l,
                                  input logic [15:0] f, input logic closing);
    in_t req;
    req = '0;
    req.kind = IN_SUBMIT;
    req.seg_addr = a;
    req.seg_len = l;
    req.seg_flags = f;
    req.seg_last = closing;
    return req;
  endfunction

  function automatic in_t poll_req(input logic [15:0] dev_idx, input logic [31:0] l);
    in_t req;
    req = '0;
    req.kind = IN_POLL;
    req.device_used_idx = dev_idx;
    req.used_entry_len = l;
    return req;
  endfunction

  function automatic out_t desc_rec(input logic [7:0] s, input logic [63:0] a,
                                    input logic [31:0] l, input logic [15:0] f,
                                    input logic [7:0] n, input logic lst);
    out_t r;
    r = '0;
    r.record_kind = REC_DESC;
    r.slot = s;
    r.desc_addr = a;
    r.desc_len = l;
    r.desc_flags = f;
    r.desc_next = n;
    r.last = lst;
    return r;
  endfunction

  function automatic out_t compl_rec(input logic [7:0] s, input logic [31:0] l);
    out_t r;
    r = '0;
    r.record_kind = REC_COMPL;
    r.slot = s;
    r.used_len = l;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_t notrdy_rec();
    out_t r;
    r = '0;
    r.record_kind = REC_NOTRDY;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic push_request(input in_t req, input bit typed = 1'b0, input out_t want = '0);
    int gap;
    int slot_at;
    gap = sender_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_full);
    slot_at = awaited_records.size();
    predict_records(req);
    if (typed) awaited_records[slot_at] = want;
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ring_size(input logic [3:0] lg);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RING_SIZE_ADDR;
    pwdata <= {28'($urandom), lg};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ring_lg = lg;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("ring_size_log2 readback", 64'(lg), 64'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stalls on pop
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else begin
      out_pop <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 25) pop_hold = stall_len();
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_records.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected request expected none got %0h", $time, out_data);
      end else begin
        want = awaited_records.pop_front();
        check_field("record_kind", 64'(want.record_kind), 64'(out_data.record_kind));
        check_field("slot", 64'(want.slot), 64'(out_data.slot));
        check_field("desc_addr", want.desc_addr, out_data.desc_addr);
        check_field("desc_len", 64'(want.desc_len), 64'(out_data.desc_len));
        check_field("desc_flags", 64'(want.desc_flags), 64'(out_data.desc_flags));
        check_field("desc_next", 64'(want.desc_next), 64'(out_data.desc_next));
        check_field("ring_head", 64'(want.ring_head), 64'(out_data.ring_head));
        check_field("new_avail_idx", 64'(want.new_avail_idx), 64'(out_data.new_avail_idx));
        check_field("used_len", 64'(want.used_len), 64'(out_data.used_len));
        check_field("last", 64'(want.last), 64'(out_data.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_t req;
    int  sent;
    int  n;
    int  pick;
    logic [3:0] lg;

    // after reset: ring of 256
    plan.push_back('{DO_REQUEST, poll_req(16'h0000, 32'h0000_1234), 4'd0, 1'b1, notrdy_rec()});
    plan.push_back('{DO_REQUEST, poll_req(16'hFFFF, 32'hFFFF_FFFF), 4'd0, 1'b1,
                     compl_rec(8'd0, 32'hFFFF_FFFF)});
    plan.push_back('{DO_REQUEST, poll_req(16'h0001, 32'hFFFF_FFFF), 4'd0, 1'b1, notrdy_rec()});
    plan.push_back('{DO_REQUEST, seg_req(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0),
                     4'd0, 1'b1, desc_rec(8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                          16'hFFFF, 8'd1, 1'b1)});
    plan.push_back('{DO_REQUEST, seg_req(64'h0, 32'h0, 16'h0000, 1'b1), 4'd0, 1'b1,
                     desc_rec(8'd1, 64'h0, 32'h0, 16'h0000, 8'd0, 1'b0)});
    plan.push_back('{DO_REQUEST, seg_req(64'h8000_0000_0000_0001, 32'h8000_0000, 16'hFFFE, 1'b1),
                     4'd0, 1'b1, desc_rec(8'd2, 64'h8000_0000_0000_0001, 32'h8000_0000,
                                          16'hFFFE, 8'd0, 1'b0)});
    plan.push_back('{DO_REQUEST, poll_req(16'h0000, 32'h0000_0001), 4'd0, 1'b1,
                     compl_rec(8'd1, 32'h0000_0001)});
    // single-entry ring, chain longer than the ring
    plan.push_back('{DO_RING_SIZE, '0, 4'd0, 1'b0, '0});
    plan.push_back('{DO_REQUEST, seg_req(64'h0123_4567_89AB_CDEF, 32'h1000, 16'h0002, 1'b0),
                     4'd0, 1'b0, '0});
    plan.push_back('{DO_REQUEST, seg_req(64'hFEDC_BA98_7654_3210, 32'h10, 16'h0000, 1'b0),
                     4'd0, 1'b0, '0});
    plan.push_back('{DO_REQUEST, seg_req(64'h5555_AAAA_5555_AAAA, 32'h7FFF_FFFF, 16'h8001, 1'b1),
                     4'd0, 1'b0, '0});
    plan.push_back('{DO_REQUEST, poll_req(16'h0005, 32'hA5A5_5A5A), 4'd0, 1'b1,
                     compl_rec(8'd0, 32'hA5A5_5A5A)});
    // oversized register, then size changed mid-chain
    plan.push_back('{DO_RING_SIZE, '0, 4'd15, 1'b0, '0});
    plan.push_back('{DO_REQUEST, seg_req(64'hAAAA_5555_AAAA_5555, 32'h200, 16'h0004, 1'b0),
                     4'd0, 1'b0, '0});
    plan.push_back('{DO_RING_SIZE, '0, 4'd1, 1'b0, '0});
    plan.push_back('{DO_REQUEST, seg_req(64'h0000_0000_FFFF_FFFF, 32'h1, 16'h0001, 1'b0),
                     4'd0, 1'b0, '0});
    plan.push_back('{DO_REQUEST, seg_req(64'hFFFF_FFFF_0000_0000, 32'h2, 16'h0003, 1'b1),
                     4'd0, 1'b0, '0});
    plan.push_back('{DO_RING_SIZE, '0, 4'd8, 1'b0, '0});
    plan.push_back('{DO_REQUEST, poll_req(16'h0003, 32'h0), 4'd0, 1'b1, notrdy_rec()});
    plan.push_back('{DO_REQUEST, seg_req(64'h1, 32'hFFFF_FFFE, 16'h7FFF, 1'b1), 4'd0, 1'b0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == DO_RING_SIZE)
        set_ring_size(plan[i].lg);
      else
        push_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // random phases: mostly well-formed chains and polls
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: lg = 4'd0;
        1: lg = 4'd15;
        2: lg = 4'd8;
        3: lg = 4'($urandom_range(1, 7));
        default: lg = 4'($urandom_range(0, 15));
      endcase
      set_ring_size(lg);
      no_idle = (p == 2);
      sent = 0;
      while (sent < 100) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          for (int s = 0; s < n; s++)
            push_request(rand_request(IN_SUBMIT, s == n - 1));
          sent += n;
        end else if (pick < 88) begin
          req = rand_request(IN_POLL, 1'($urandom));
          if ($urandom_range(0, 1) == 0) req.device_used_idx = reaped;
          push_request(req);
          sent++;
        end else if (pick < 97) begin
          push_request(rand_request(IN_SUBMIT, 1'($urandom)));
          sent++;
        end else begin
          wait_idle();
        end
      end
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/srdp_pkg.sv
rtl/core/srdp_front.sv
rtl/core/srdp_fifo.sv
rtl/core/srdp_back.sv
rtl/core/split_ring_descriptor_producer_top.sv
test/tb_top.sv
